FILE: rtl/tpfc_pkg.sv
// ----------------------------------------------------------------------------
// tpfc_pkg: shared types and constants of the touch point filter
// Word layouts, register indexes, reject causes and filter constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tpfc_pkg;

	// converter sample after the shift by 3
	localparam int SAMPLE_W = 13;
	localparam int RAW_W    = 16;
	localparam int RAW_SHIFT = 3;
	localparam int POS_W    = 16;
	localparam int GAIN_W   = 32;
	localparam int OFFS_W   = 16;
	localparam int GAIN_FRAC = 24;

	// four groups in a capture: X, Y, X, Y
	localparam int GRP_W    = 2;
	localparam logic [GRP_W-1:0] GRP_LAST = 2'd3;

	// default filter geometry
	localparam int SAMPLES_PER_READ_DEF = 9;
	localparam int JITTER_LIMIT_DEF     = 50;

	// divide by three via reciprocal: exact for sums below 2^17
	localparam int DIV3_SHIFT = 17;
	localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = 17'd43691;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X    = 3'd0,
		REG_MAX_X    = 3'd1,
		REG_MIN_Y    = 3'd2,
		REG_MAX_Y    = 3'd3,
		REG_X_GAIN   = 3'd4,
		REG_Y_GAIN   = 3'd5,
		REG_X_OFFSET = 3'd6,
		REG_Y_OFFSET = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		CAUSE_OK     = 2'd0,
		CAUSE_WINDOW = 2'd1,
		CAUSE_JITTER = 2'd2
	} cause_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_word;
		logic             restart;
	} in_word_t;

	typedef struct packed {
		logic             point_valid;
		logic [1:0]       reject_cause;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} out_word_t;

	// calibration register set
	typedef struct packed {
		logic [SAMPLE_W-1:0]      min_x;
		logic [SAMPLE_W-1:0]      max_x;
		logic [SAMPLE_W-1:0]      min_y;
		logic [SAMPLE_W-1:0]      max_y;
		logic signed [GAIN_W-1:0] x_gain;
		logic signed [GAIN_W-1:0] y_gain;
		logic signed [OFFS_W-1:0] x_offset;
		logic signed [OFFS_W-1:0] y_offset;
	} cfg_t;

	// one trimmed mean leaving the sort chain
	typedef struct packed {
		logic                valid;
		logic [GRP_W-1:0]    grp;
		logic [SAMPLE_W-1:0] value;
	} filt_t;

endpackage

`default_nettype wire

FILE: rtl/tpfc_sort_cell.sv
// ----------------------------------------------------------------------------
// tpfc_sort_cell: one cell of the insertion sort chain
// Holds one sorted sample; keeps it, takes its left neighbour or the new one.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfc_sort_cell (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           shift_en,
	input  wire                           clear,
	input  wire  [tpfc_pkg::SAMPLE_W-1:0] sample,
	input  wire  [tpfc_pkg::SAMPLE_W-1:0] left_val,
	input  wire                           left_live,
	output logic [tpfc_pkg::SAMPLE_W-1:0] val,
	output logic                          live
);
	import tpfc_pkg::*;

	logic [SAMPLE_W-1:0] val_q;
	logic                valid_q;
	logic                own_live;
	logic                keep;
	logic                take_left;

	// decide where this cell's next value comes from
	always_comb begin
		own_live  = valid_q & ~clear;
		keep      = own_live && (val_q <= sample);
		take_left = left_live && (left_val > sample);
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en && !keep) begin
			valid_q <= left_live;
		end
	end

	// value: hold, shift right from the neighbour, or insert the new sample
	always_ff @(posedge clk) begin
		if (shift_en && !keep) begin
			if (take_left) begin
				val_q <= left_val;
			end else begin
				val_q <= sample;
			end
		end
	end

	assign val  = val_q;
	assign live = valid_q;

endmodule

`default_nettype wire

FILE: rtl/tpfc_sort_chain.sv
// ----------------------------------------------------------------------------
// tpfc_sort_chain: row of sort cells and trimmed mean of one group
// Sorts a group as it arrives, then averages the middle three samples.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfc_sort_chain #(
	parameter int SAMPLES_PER_READ = tpfc_pkg::SAMPLES_PER_READ_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           ins,
	input  wire                           first,
	input  wire                           last,
	input  wire  [tpfc_pkg::GRP_W-1:0]    grp,
	input  wire  [tpfc_pkg::SAMPLE_W-1:0] sample,
	output tpfc_pkg::filt_t               filt
);
	import tpfc_pkg::*;

	localparam int MID   = (SAMPLES_PER_READ - 3) / 2;
	localparam int SUM_W = SAMPLE_W + 2;
	localparam int PROD_W = SUM_W + DIV3_SHIFT;

	logic [SAMPLE_W-1:0] cell_val  [SAMPLES_PER_READ];
	logic                cell_live [SAMPLES_PER_READ];
	logic [SAMPLE_W-1:0] left_val  [SAMPLES_PER_READ];
	logic                left_live [SAMPLES_PER_READ];

	logic                done_s1;
	logic [GRP_W-1:0]    grp_s1;
	logic                done_s2;
	logic [GRP_W-1:0]    grp_s2;
	logic [SUM_W-1:0]    sum_s2;
	logic                done_s3;
	logic [GRP_W-1:0]    grp_s3;
	logic [SAMPLE_W-1:0] mean_s3;
	logic [PROD_W-1:0]   div_prod;

	// neighbour links; the head sees an always live, empty left side
	always_comb begin
		for (int i = 0; i < SAMPLES_PER_READ; i++) begin
			if (i == 0) begin
				left_val[i]  = '0;
				left_live[i] = 1'b1;
			end else begin
				left_val[i]  = cell_val[i-1];
				left_live[i] = cell_live[i-1] & ~first;
			end
		end
	end

	for (genvar g = 0; g < SAMPLES_PER_READ; g++) begin : g_cell
		tpfc_sort_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (ins),
			.clear     (first),
			.sample    (sample),
			.left_val  (left_val[g]),
			.left_live (left_live[g]),
			.val       (cell_val[g]),
			.live      (cell_live[g])
		);
	end

	assign div_prod = PROD_W'(sum_s2) * PROD_W'(DIV3_RECIP);

	// flag a complete group, sum its middle three, then divide by three
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			done_s2 <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			done_s1 <= ins & last;
			done_s2 <= done_s1;
			done_s3 <= done_s2;
		end
	end

	always_ff @(posedge clk) begin
		grp_s1  <= grp;
		grp_s2  <= grp_s1;
		sum_s2  <= SUM_W'(cell_val[MID]) + SUM_W'(cell_val[MID+1])
			+ SUM_W'(cell_val[MID+2]);
		grp_s3  <= grp_s2;
		mean_s3 <= div_prod[DIV3_SHIFT +: SAMPLE_W];
	end

	assign filt.valid = done_s3;
	assign filt.grp   = grp_s3;
	assign filt.value = mean_s3;

endmodule

`default_nettype wire

FILE: rtl/tpfc_calib.sv
// ----------------------------------------------------------------------------
// tpfc_calib: capture check and calibration mapping
// Stores the first three means, checks window and jitter, scales and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfc_calib #(
	parameter int JITTER_LIMIT = tpfc_pkg::JITTER_LIMIT_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire tpfc_pkg::filt_t filt,
	input  wire tpfc_pkg::cfg_t  cfg,
	input  wire                  out_stall,
	output logic                 out_valid,
	output tpfc_pkg::out_word_t  out_word
);
	import tpfc_pkg::*;

	localparam logic [SAMPLE_W-1:0] JIT_LIM = SAMPLE_W'(JITTER_LIMIT);
	localparam int PROD_W = SAMPLE_W + 1 + GAIN_W;
	localparam int QUOT_W = PROD_W - GAIN_FRAC;
	localparam int SUM_W  = QUOT_W + 1;

	logic [SAMPLE_W-1:0] reads_q [3];

	logic [SAMPLE_W-1:0] x0, y0, x1, y1;
	logic [SAMPLE_W-1:0] dx, dy;
	logic                win_bad, jit_bad;

	logic                v_s1;
	cause_t              cause_s1;
	logic [SAMPLE_W-1:0] avgx_s1, avgy_s1;

	logic                     v_s2;
	cause_t                   cause_s2;
	logic signed [PROD_W-1:0] prodx_s2, prody_s2;

	logic [POS_W-1:0] posx, posy;
	logic             out_valid_q;
	out_word_t        out_word_q;

	// keep the first three means of the capture
	always_ff @(posedge clk) begin
		if (filt.valid && filt.grp != GRP_LAST) begin
			reads_q[filt.grp] <= filt.value;
		end
	end

	// window check on the first X/Y pair, jitter check between the two pairs
	always_comb begin
		x0 = reads_q[0];
		y0 = reads_q[1];
		x1 = reads_q[2];
		y1 = filt.value;
		dx = (x0 > x1) ? x0 - x1 : x1 - x0;
		dy = (y0 > y1) ? y0 - y1 : y1 - y0;
		win_bad = (x0 > cfg.max_x) || (x0 < cfg.min_x)
			|| (y0 > cfg.max_y) || (y0 < cfg.min_y);
		jit_bad = (dx > JIT_LIM) || (dy > JIT_LIM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= filt.valid && filt.grp == GRP_LAST;
			v_s2 <= v_s1;
		end
	end

	// register cause and pair averages, then the gain products
	always_ff @(posedge clk) begin
		if (win_bad) begin
			cause_s1 <= CAUSE_WINDOW;
		end else if (jit_bad) begin
			cause_s1 <= CAUSE_JITTER;
		end else begin
			cause_s1 <= CAUSE_OK;
		end
		avgx_s1  <= SAMPLE_W'(((SAMPLE_W+1)'(x0) + (SAMPLE_W+1)'(x1)) >> 1);
		avgy_s1  <= SAMPLE_W'(((SAMPLE_W+1)'(y0) + (SAMPLE_W+1)'(y1)) >> 1);
		cause_s2 <= cause_s1;
		prodx_s2 <= PROD_W'($signed({1'b0, avgx_s1})) * PROD_W'(cfg.x_gain);
		prody_s2 <= PROD_W'($signed({1'b0, avgy_s1})) * PROD_W'(cfg.y_gain);
	end

	// drop the fraction toward zero, add offset, clamp to screen range
	function automatic logic [POS_W-1:0] map_axis(
		input logic signed [PROD_W-1:0] prod,
		input logic signed [OFFS_W-1:0] offs
	);
		logic signed [PROD_W-1:0] biased;
		logic signed [QUOT_W-1:0] quot;
		logic signed [SUM_W-1:0]  sum;
		biased = prod[PROD_W-1] ? prod + PROD_W'({GAIN_FRAC{1'b1}}) : prod;
		quot   = QUOT_W'(biased >>> GAIN_FRAC);
		sum    = SUM_W'(quot) + SUM_W'(offs);
		if (sum < 0) begin
			map_axis = '0;
		end else if (sum > SUM_W'({POS_W{1'b1}})) begin
			map_axis = '1;
		end else begin
			map_axis = sum[POS_W-1:0];
		end
	endfunction

	assign posx = map_axis(prodx_s2, cfg.x_offset);
	assign posy = map_axis(prody_s2, cfg.y_offset);

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s2) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			out_word_q.point_valid  <= cause_s2 == CAUSE_OK;
			out_word_q.reject_cause <= cause_s2;
			out_word_q.pos_x        <= (cause_s2 == CAUSE_OK) ? posx : '0;
			out_word_q.pos_y        <= (cause_s2 == CAUSE_OK) ? posy : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

FILE: rtl/touch_point_filter_calibrate_top.sv
// ----------------------------------------------------------------------------
// touch_point_filter_calibrate_top: trimmed-mean touch filter with calibration
// Sorts each group of converter samples in a cell chain, checks the capture
// and maps the averaged X/Y pair to screen coordinates.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           word
//  in        sink       in_valid/in_stall   raw_word, restart
//  out       source     out_valid/out_stall point_valid, reject_cause, pos_x, pos_y
//  cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
//  Words enter one per cycle while a capture is collected; each cell of the
//  sort chain inserts in the cycle the word arrives.
//  The last word of a capture starts a tail (mean, check, multiply,
//  clamp); in_stall stays high from then until the result word is taken.
//  Reset clears counters and valid flags; no clearing pass is needed.
//  A restart word opens a new capture and drops any partial one.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_point_filter_calibrate_top #(
	parameter int SAMPLES_PER_READ = tpfc_pkg::SAMPLES_PER_READ_DEF,
	parameter int JITTER_LIMIT     = tpfc_pkg::JITTER_LIMIT_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire tpfc_pkg::in_word_t         in_word,
	output logic                            out_valid,
	input  wire                             out_stall,
	output tpfc_pkg::out_word_t             out_word,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [tpfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [tpfc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tpfc_pkg::*;

	localparam int CNT_W = $clog2(SAMPLES_PER_READ);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READ - 1);

	logic [CNT_W-1:0] pos_q;
	logic [GRP_W-1:0] grp_q;
	logic             busy_q;
	cfg_t             cfg_q;

	logic             in_acc;
	logic             cap_last;
	logic [CNT_W-1:0] pos_e;
	logic [GRP_W-1:0] grp_e;
	logic             last_e;
	filt_t            filt;

	assign in_acc    = in_valid & ~in_stall;
	assign in_stall  = busy_q;
	assign cfg_ready = 1'b1;

	// position of this word within the capture
	always_comb begin
		pos_e    = in_word.restart ? '0 : pos_q;
		grp_e    = in_word.restart ? '0 : grp_q;
		last_e   = pos_e == CNT_LAST;
		cap_last = last_e && grp_e == GRP_LAST;
	end

	// advance the word counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			grp_q <= '0;
		end else if (in_acc) begin
			if (last_e) begin
				pos_q <= '0;
				grp_q <= grp_e + GRP_W'(1);
			end else begin
				pos_q <= pos_e + CNT_W'(1);
				grp_q <= grp_e;
			end
		end
	end

	// hold off input from the last word until the result word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc && cap_last) begin
			busy_q <= 1'b1;
		end else if (out_valid && !out_stall) begin
			busy_q <= 1'b0;
		end
	end

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x    <= '0;
			cfg_q.max_x    <= '1;
			cfg_q.min_y    <= '0;
			cfg_q.max_y    <= '1;
			cfg_q.x_gain   <= GAIN_W'(1) << GAIN_FRAC;
			cfg_q.y_gain   <= GAIN_W'(1) << GAIN_FRAC;
			cfg_q.x_offset <= '0;
			cfg_q.y_offset <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_X:    cfg_q.min_x    <= cfg_data[SAMPLE_W-1:0];
				REG_MAX_X:    cfg_q.max_x    <= cfg_data[SAMPLE_W-1:0];
				REG_MIN_Y:    cfg_q.min_y    <= cfg_data[SAMPLE_W-1:0];
				REG_MAX_Y:    cfg_q.max_y    <= cfg_data[SAMPLE_W-1:0];
				REG_X_GAIN:   cfg_q.x_gain   <= cfg_data[GAIN_W-1:0];
				REG_Y_GAIN:   cfg_q.y_gain   <= cfg_data[GAIN_W-1:0];
				REG_X_OFFSET: cfg_q.x_offset <= cfg_data[OFFS_W-1:0];
				REG_Y_OFFSET: cfg_q.y_offset <= cfg_data[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	tpfc_sort_chain #(
		.SAMPLES_PER_READ (SAMPLES_PER_READ)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ins    (in_acc),
		.first  (pos_e == '0),
		.last   (last_e),
		.grp    (grp_e),
		.sample (in_word.raw_word[RAW_W-1:RAW_SHIFT]),
		.filt   (filt)
	);

	tpfc_calib #(
		.JITTER_LIMIT (JITTER_LIMIT)
	) u_calib (
		.clk       (clk),
		.arst_n    (arst_n),
		.filt      (filt),
		.cfg       (cfg_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

	// a result only ever appears inside a finished capture
	a_out_in_busy : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy_q)
		else $error("result word outside a capture tail");

	// last word of a capture locks the input side
	a_last_locks : assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cap_last) |=> in_stall)
		else $error("input not held after last word");

	// accept flag agrees with the cause, rejected words carry zero position
	a_cause_flag : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.point_valid == (out_word.reject_cause == CAUSE_OK)))
		else $error("point_valid disagrees with reject_cause");

	a_reject_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.point_valid) |-> (out_word.pos_x == '0
			&& out_word.pos_y == '0))
		else $error("rejected word carries a position");

	// the group tail never overlaps the next result word being formed
	a_no_filt_when_out : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !filt.valid)
		else $error("mean leaves the chain while a result waits");

endmodule

`default_nettype wire
